/* rtl/core/hps_pkg.sv */
// shared types and constants of the heater power setpoint block
`timescale 1ns / 1ps
`default_nettype none

package hps_pkg;

	localparam int PWR_W      = 16;
	localparam int DUTY_W     = 10;
	localparam int NUM_W      = PWR_W + DUTY_W;
	localparam int MODE_W     = 3;
	localparam int GRID_W     = 19;
	localparam int TEMP_W     = 12;
	localparam int LIMIT_W    = 11;
	localparam int TIMEOUT_W  = 20;
	localparam int AGE_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int RECIP_W    = 47;

	// one divider cell per quotient bit
	localparam int NUM_CELLS = DUTY_W;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PV     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MANUAL = 3'd2;
	localparam logic [MODE_W-1:0] MODE_BURST  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TEST   = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_POWER    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MANUAL_POWER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_GRID  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BURST        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_TIMEOUT = 3'd7;

	// register reset values
	localparam logic [PWR_W-1:0]     MAX_POWER_RST    = 16'd3500;
	localparam logic [LIMIT_W-1:0]   TEMP_LIMIT_RST   = 11'd850;
	localparam logic [TIMEOUT_W-1:0] LINK_TIMEOUT_RST = 20'd3000;

	// saturation bounds
	localparam logic [LIMIT_W-1:0]   TEMP_LIMIT_LO = 11'd300;
	localparam logic [LIMIT_W-1:0]   TEMP_LIMIT_HI = 11'd1200;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_MIN   = 20'd250;
	localparam logic [DUTY_W-1:0]    DUTY_FULL     = 10'd1000;
	localparam logic [DUTY_W-1:0]    TEST_DUTY     = 10'd100;

	// x / 1000 == (x >> 3) * RECIP_125 >> RECIP_SHIFT, exact for x < 2**26
	localparam int                RECIP_SHIFT = 30;
	localparam logic [23:0]       RECIP_125   = 24'd8589935;

	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [PWR_W-1:0]     max_power;
		logic [PWR_W-1:0]     min_power;
		logic [PWR_W-1:0]     manual_power;
		logic [GRID_W-1:0]    target_grid;
		logic [DUTY_W-1:0]    burst_permille;
		logic [LIMIT_W-1:0]   temp_limit;
		logic [TIMEOUT_W-1:0] link_timeout;
	} hps_cfg_t;

	typedef struct packed {
		logic              run_enable;
		logic              estop;
		logic [AGE_W-1:0]  link_age;
		logic              temps_ok;
		logic [TEMP_W-1:0] tank_top;
		logic [TEMP_W-1:0] tank_mid;
		logic [TEMP_W-1:0] tank_bottom;
		logic [TEMP_W-1:0] flow_temp;
		logic [TEMP_W-1:0] return_temp;
		logic [GRID_W-1:0] grid_power;
	} hps_tick_t;

	// item as it travels down the divider chain
	typedef struct packed {
		logic              zero;
		logic              use_div;
		logic [PWR_W-1:0]  maxp;
		logic [PWR_W-1:0]  power;
		logic [DUTY_W-1:0] duty;
		logic [PWR_W-1:0]  rem;
		logic [DUTY_W-1:0] low;
	} hps_item_t;

endpackage

`default_nettype wire

/* rtl/core/hps_if.sv */
// request channel interfaces for the control tick and the setpoint result
`timescale 1ns / 1ps
`default_nettype none

interface hps_in_if;
	logic               valid;
	logic               ready;
	logic               run_enable;
	logic               estop;
	logic [31:0]        link_age;
	logic               temps_ok;
	logic signed [11:0] tank_top;
	logic signed [11:0] tank_mid;
	logic signed [11:0] tank_bottom;
	logic signed [11:0] flow_temp;
	logic signed [11:0] return_temp;
	logic signed [18:0] grid_power;

	modport source (
		output valid, run_enable, estop, link_age, temps_ok, tank_top, tank_mid,
			tank_bottom, flow_temp, return_temp, grid_power,
		input  ready
	);
	modport sink (
		input  valid, run_enable, estop, link_age, temps_ok, tank_top, tank_mid,
			tank_bottom, flow_temp, return_temp, grid_power,
		output ready
	);
endinterface

interface hps_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] power_setpoint;
	logic [9:0]  duty;
	logic        drive_on;

	modport source (
		output valid, power_setpoint, duty, drive_on,
		input  ready
	);
	modport sink (
		input  valid, power_setpoint, duty, drive_on,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/core/heater_power_setpoint.sv */
// heater power setpoint: top level with configuration registers and output register
//
// tick (sink) carries one control tick: enable, emergency stop, link age, temperature
// validity, five temperatures in 0.1 degC and grid power. result (source) returns one
// setpoint per tick: power in W, duty in permille and the drive enable, all zero when
// an interlock trips, the mode is off or undefined or the computed power or duty is zero.
// registers are written through cfg_we / cfg_idx / cfg_wdata only while no tick is in
// flight; this binds the user, the block itself has no check for it.
// the accepting edge loads the first of three front stages, then ten divider cells (one
// duty bit per cell) and one output register follow.
// throughput: one tick per cycle while result is not stalled; each tick walks through
// the ten-cell divider chain.
// every stage has its own valid and hands on when the next stage is free, so while
// result is stalled the stages behind it keep filling; tick.ready drops only when all
// fourteen stages hold a request.
// reset clears the pipeline and loads the register defaults (mode off, 3500 W max,
// 85.0 degC limit, 3000 ms link timeout).
`timescale 1ns / 1ps
`default_nettype none

module heater_power_setpoint (
	input  logic                             clk,
	input  logic                             arst_n,
	hps_in_if.sink                           tick,
	hps_out_if.source                        result,
	input  logic                             cfg_we,
	input  logic [hps_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [hps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import hps_pkg::*;

	hps_cfg_t  cfg_q;
	hps_tick_t tick_in;

	logic      cv [0:NUM_CELLS];
	logic      cr [0:NUM_CELLS];
	hps_item_t ci [0:NUM_CELLS];

	logic              out_valid_q;
	logic [PWR_W-1:0]  power_q;
	logic [DUTY_W-1:0] duty_q;
	logic              drive_q;
	hps_item_t         last;
	logic              last_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= MODE_OFF;
			cfg_q.max_power      <= MAX_POWER_RST;
			cfg_q.min_power      <= '0;
			cfg_q.manual_power   <= '0;
			cfg_q.target_grid    <= '0;
			cfg_q.burst_permille <= '0;
			cfg_q.temp_limit     <= TEMP_LIMIT_RST;
			cfg_q.link_timeout   <= LINK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MODE:         cfg_q.mode           <= cfg_wdata[MODE_W-1:0];
				REG_MAX_POWER:    cfg_q.max_power      <= cfg_wdata[PWR_W-1:0];
				REG_MIN_POWER:    cfg_q.min_power      <= cfg_wdata[PWR_W-1:0];
				REG_MANUAL_POWER: cfg_q.manual_power   <= cfg_wdata[PWR_W-1:0];
				REG_TARGET_GRID:  cfg_q.target_grid    <= cfg_wdata[GRID_W-1:0];
				REG_BURST:        cfg_q.burst_permille <= cfg_wdata[DUTY_W-1:0];
				REG_TEMP_LIMIT:   cfg_q.temp_limit     <= cfg_wdata[LIMIT_W-1:0];
				REG_LINK_TIMEOUT: cfg_q.link_timeout   <= cfg_wdata[TIMEOUT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign tick_in.run_enable  = tick.run_enable;
	assign tick_in.estop       = tick.estop;
	assign tick_in.link_age    = tick.link_age;
	assign tick_in.temps_ok    = tick.temps_ok;
	assign tick_in.tank_top    = tick.tank_top;
	assign tick_in.tank_mid    = tick.tank_mid;
	assign tick_in.tank_bottom = tick.tank_bottom;
	assign tick_in.flow_temp   = tick.flow_temp;
	assign tick_in.return_temp = tick.return_temp;
	assign tick_in.grid_power  = tick.grid_power;

	hps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (tick.valid),
		.in_ready  (tick.ready),
		.in_tick   (tick_in),
		.out_valid (cv[0]),
		.out_ready (cr[0]),
		.out_item  (ci[0])
	);

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		hps_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[g]),
			.in_ready  (cr[g]),
			.in_item   (ci[g]),
			.out_valid (cv[g+1]),
			.out_ready (cr[g+1]),
			.out_item  (ci[g+1])
		);
	end

	assign cr[NUM_CELLS] = !out_valid_q || result.ready;
	assign last          = ci[NUM_CELLS];
	// no positive power or duty means everything off
	assign last_zero     = last.zero || (last.power == '0) || (last.duty == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cr[NUM_CELLS]) begin
			out_valid_q <= cv[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (cr[NUM_CELLS] && cv[NUM_CELLS]) begin
			power_q <= last_zero ? '0 : last.power;
			duty_q  <= last_zero ? '0 : last.duty;
			drive_q <= !last_zero;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.power_setpoint = power_q;
	assign result.duty           = duty_q;
	assign result.drive_on       = drive_q;

`ifndef SYNTHESIS
	a_off_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.drive_on) |-> (result.power_setpoint == '0 && result.duty == '0))
		else $error("drive off with nonzero setpoint");

	a_within_max: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.drive_on)
			|-> (result.power_setpoint <= cfg_q.max_power && result.duty <= DUTY_FULL))
		else $error("setpoint beyond max power or full duty");

	a_mode_off: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && cfg_q.mode == MODE_OFF) |-> !result.drive_on)
		else $error("drive on while mode is off");

	a_test_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.drive_on && cfg_q.mode == MODE_TEST)
			|-> (result.duty == TEST_DUTY))
		else $error("test mode duty wrong");
`endif

endmodule

`default_nettype wire

/* rtl/core/hps_front.sv */
// interlock checks, mode decode and constant-divisor path ahead of the divider chain
`timescale 1ns / 1ps
`default_nettype none

module hps_front (
	input  logic             clk,
	input  logic             arst_n,
	input  hps_pkg::hps_cfg_t  cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  hps_pkg::hps_tick_t in_tick,
	output logic             out_valid,
	input  logic             out_ready,
	output hps_pkg::hps_item_t out_item
);
	import hps_pkg::*;

	typedef struct packed {
		logic              zero;
		logic              use_div;
		logic              do_clamp;
		logic [PWR_W-1:0]  power;
		logic [DUTY_W-1:0] duty;
		logic [PWR_W-1:0]  maxp;
		logic [PWR_W-1:0]  minp;
		logic [NUM_W-1:0]  prod;
	} front1_t;

	typedef struct packed {
		logic               zero;
		logic               use_div;
		logic               do_clamp;
		logic [PWR_W-1:0]   power;
		logic [DUTY_W-1:0]  duty;
		logic [PWR_W-1:0]   maxp;
		logic [PWR_W-1:0]   minp;
		logic [NUM_W-1:0]   num;
		logic [RECIP_W-1:0] recip;
	} front2_t;

	logic      valid_s1, valid_s2, valid_s3;
	logic      adv1, adv2, adv3;
	front1_t   st_s1, st1_n;
	front2_t   st_s2, st2_n;
	hps_item_t item_s3, item3_n;

	logic [PWR_W-1:0]     maxp, minp, man_pwr, pv_pwr;
	logic [LIMIT_W-1:0]   limit;
	logic [TIMEOUT_W-1:0] timeout;
	logic signed [TEMP_W:0] limit_s;
	logic signed [GRID_W:0] diff;
	logic [DUTY_W-1:0]    burst_d, d_sel;
	logic                 hot, ok, mode_ok;
	logic [PWR_W-1:0]     q1000, bpwr;

	assign adv3     = !valid_s3 || out_ready;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	// stage 1: interlocks, saturated registers, clamps, burst/test product
	always_comb begin
		maxp    = cfg.max_power;
		minp    = (cfg.min_power > cfg.max_power) ? cfg.max_power : cfg.min_power;
		limit   = cfg.temp_limit;
		if (cfg.temp_limit < TEMP_LIMIT_LO) begin
			limit = TEMP_LIMIT_LO;
		end else if (cfg.temp_limit > TEMP_LIMIT_HI) begin
			limit = TEMP_LIMIT_HI;
		end
		timeout = (cfg.link_timeout < TIMEOUT_MIN) ? TIMEOUT_MIN : cfg.link_timeout;
		limit_s = $signed({2'b00, limit});
		hot = ($signed({in_tick.tank_top[TEMP_W-1], in_tick.tank_top}) >= limit_s)
			|| ($signed({in_tick.tank_mid[TEMP_W-1], in_tick.tank_mid}) >= limit_s)
			|| ($signed({in_tick.tank_bottom[TEMP_W-1], in_tick.tank_bottom}) >= limit_s)
			|| ($signed({in_tick.flow_temp[TEMP_W-1], in_tick.flow_temp}) >= limit_s)
			|| ($signed({in_tick.return_temp[TEMP_W-1], in_tick.return_temp}) >= limit_s);
		ok = in_tick.run_enable && !in_tick.estop && in_tick.temps_ok && !hot
			&& (in_tick.link_age <= AGE_W'(timeout)) && (maxp != '0);

		diff = $signed({cfg.target_grid[GRID_W-1], cfg.target_grid})
			- $signed({in_tick.grid_power[GRID_W-1], in_tick.grid_power});
		if (diff < $signed({4'b0000, minp})) begin
			pv_pwr = minp;
		end else if (diff > $signed({4'b0000, maxp})) begin
			pv_pwr = maxp;
		end else begin
			pv_pwr = diff[PWR_W-1:0];
		end
		if (cfg.manual_power < minp) begin
			man_pwr = minp;
		end else if (cfg.manual_power > maxp) begin
			man_pwr = maxp;
		end else begin
			man_pwr = cfg.manual_power;
		end
		burst_d = (cfg.burst_permille > DUTY_FULL) ? DUTY_FULL : cfg.burst_permille;

		mode_ok        = 1'b1;
		d_sel          = '0;
		st1_n.use_div  = 1'b0;
		st1_n.do_clamp = 1'b0;
		st1_n.power    = '0;
		st1_n.duty     = '0;
		case (cfg.mode)
			MODE_PV: begin
				st1_n.use_div = 1'b1;
				st1_n.power   = pv_pwr;
			end
			MODE_MANUAL: begin
				st1_n.use_div = 1'b1;
				st1_n.power   = man_pwr;
			end
			MODE_BURST: begin
				d_sel          = burst_d;
				st1_n.duty     = burst_d;
				st1_n.do_clamp = 1'b1;
			end
			MODE_TEST: begin
				// max_power * 100 / 1000 is max_power / 10
				d_sel      = TEST_DUTY;
				st1_n.duty = TEST_DUTY;
			end
			default: begin
				mode_ok = 1'b0;
			end
		endcase
		st1_n.zero = !ok || !mode_ok;
		st1_n.maxp = maxp;
		st1_n.minp = minp;
		st1_n.prod = NUM_W'(maxp) * NUM_W'(d_sel);
	end

	// stage 2: dividend for the chain, reciprocal product for the constant path
	always_comb begin
		st2_n.zero     = st_s1.zero;
		st2_n.use_div  = st_s1.use_div;
		st2_n.do_clamp = st_s1.do_clamp;
		st2_n.power    = st_s1.power;
		st2_n.duty     = st_s1.duty;
		st2_n.maxp     = st_s1.maxp;
		st2_n.minp     = st_s1.minp;
		st2_n.num      = NUM_W'(st_s1.power) * NUM_W'(DUTY_FULL);
		st2_n.recip    = RECIP_W'(st_s1.prod[NUM_W-1:3]) * RECIP_W'(RECIP_125);
	end

	// stage 3: finish the divide by 1000 and clamp burst power
	always_comb begin
		q1000 = st_s2.recip[RECIP_SHIFT +: PWR_W];
		bpwr  = q1000;
		if (st_s2.do_clamp) begin
			if (q1000 < st_s2.minp) begin
				bpwr = st_s2.minp;
			end else if (q1000 > st_s2.maxp) begin
				bpwr = st_s2.maxp;
			end
		end
		item3_n.zero    = st_s2.zero;
		item3_n.use_div = st_s2.use_div;
		item3_n.maxp    = st_s2.maxp;
		item3_n.power   = st_s2.use_div ? st_s2.power : bpwr;
		item3_n.duty    = st_s2.use_div ? '0 : st_s2.duty;
		item3_n.rem     = st_s2.num[NUM_W-1:DUTY_W];
		item3_n.low     = st_s2.num[DUTY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			st_s1 <= st1_n;
		end
		if (adv2 && valid_s1) begin
			st_s2 <= st2_n;
		end
		if (adv3 && valid_s2) begin
			item_s3 <= item3_n;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule

`default_nettype wire

/* rtl/core/hps_cell.sv */
// one restoring divider cell: for a use_div item brings down a dividend bit and yields one duty bit
`timescale 1ns / 1ps
`default_nettype none

module hps_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  hps_pkg::hps_item_t in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output hps_pkg::hps_item_t out_item
);
	import hps_pkg::*;

	logic              valid_q;
	hps_item_t         item_q, item_n;
	logic [PWR_W:0]    rem_sh;
	logic              take;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		item_n = in_item;
		rem_sh = {in_item.rem, in_item.low[DUTY_W-1]};
		take   = rem_sh >= {1'b0, in_item.maxp};
		if (in_item.use_div) begin
			item_n.rem  = take ? PWR_W'(rem_sh - {1'b0, in_item.maxp}) : rem_sh[PWR_W-1:0];
			item_n.low  = {in_item.low[DUTY_W-2:0], 1'b0};
			item_n.duty = {in_item.duty[DUTY_W-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= item_n;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

`default_nettype wire
